/* rtl/rle_icon_pixel_decoder_unit_assert.svh */
// Assertion macros shared by the decoder modules.
// Each takes a label, clock, reset, a trigger and a consequence.
`ifndef RLE_ICON_PIXEL_DECODER_UNIT_ASSERT_SVH
`define RLE_ICON_PIXEL_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// consequence holds in the same cycle as the trigger
`define RLEICON_ASSERT_IMPL(lbl, clk, rst, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// consequence holds in the cycle after the trigger
`define RLEICON_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define RLEICON_ASSERT_IMPL(lbl, clk, rst, trig, cons)
`define RLEICON_ASSERT_NEXT(lbl, clk, rst, trig, cons)
`endif

`endif

/* rtl/rleicon_pkg.sv */
package rleicon_pkg;

  // fixed field widths
  localparam int ADDR_W      = 15;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int LIT_PIXELS  = 7;

  // code byte layout
  localparam int RUN_FLAG_BIT  = 7;
  localparam int RUN_VALUE_BIT = 6;

  // depth of the queue between front and back (power of two)
  localparam int QDEPTH = 2;

  // register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ICON_WIDTH  = 3'd0,
    REG_ICON_HEIGHT = 3'd1,
    REG_ORIGIN_X    = 3'd2,
    REG_ORIGIN_Y    = 3'd3,
    REG_INK_COLOR   = 3'd4
  } rleicon_reg_t;

  // classified code byte
  typedef struct packed {
    logic       is_run;
    logic [5:0] count;
    logic [6:0] bits;   // literal pixels, or run value in bit 0
  } rleicon_item_t;

  // configuration registers
  typedef struct packed {
    logic [7:0]  icon_width;
    logic [7:0]  icon_height;
    logic [10:0] origin_x;  // two's complement
    logic [10:0] origin_y;  // two's complement
    logic [3:0]  ink_color;
  } rleicon_cfg_t;

  // one placed pixel before address generation
  typedef struct packed {
    logic [11:0] sx;   // two's complement screen column
    logic [11:0] sy;   // two's complement screen row
    logic        inked;
    logic        done;
    logic        last;
    logic [3:0]  color;
  } rleicon_pix_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } rleicon_state_t;

endpackage

/* rtl/rleicon_front.sv */
`include "rle_icon_pixel_decoder_unit_assert.svh"

module rleicon_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             code_byte,
  input  logic                   push,
  output logic                   full,
  output rleicon_pkg::rleicon_item_t item,
  output logic                   item_valid,
  input  logic                   item_pop
);

  localparam int QPTR_W = (rleicon_pkg::QDEPTH > 1) ? $clog2(rleicon_pkg::QDEPTH) : 1;
  localparam logic [QPTR_W:0] FILL_MAX = (QPTR_W+1)'(rleicon_pkg::QDEPTH);

  rleicon_pkg::rleicon_item_t item_in;
  rleicon_pkg::rleicon_item_t mem [rleicon_pkg::QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              wr_en;
  logic              rd_en;

  // classify the incoming word
  always_comb begin
    item_in.is_run = code_byte[rleicon_pkg::RUN_FLAG_BIT];
    if (item_in.is_run) begin
      item_in.count = code_byte[5:0];
      item_in.bits  = {6'b0, code_byte[rleicon_pkg::RUN_VALUE_BIT]};
    end else begin
      item_in.count = 6'(rleicon_pkg::LIT_PIXELS);
      item_in.bits  = code_byte[6:0];
    end
  end

  assign full       = (fill == FILL_MAX);
  assign item_valid = (fill != '0);
  assign wr_en      = push && !full;
  assign rd_en      = item_pop && item_valid;
  assign item       = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= item_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  `RLEICON_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill <= FILL_MAX)
  `RLEICON_ASSERT_NEXT(a_fill_up, clk, rst, wr_en && !rd_en, fill == $past(fill) + 1'b1)
  `RLEICON_ASSERT_NEXT(a_full_holds, clk, rst, full && !rd_en, full)

endmodule

/* rtl/rleicon_back.sv */
`include "rle_icon_pixel_decoder_unit_assert.svh"

module rleicon_back #(
  parameter int SCREEN_W = 240,
  parameter int SCREEN_H = 135
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rleicon_pkg::rleicon_cfg_t   cfg,
  input  rleicon_pkg::rleicon_item_t  item,
  input  logic                        item_valid,
  output logic                        item_pop,
  output logic [rleicon_pkg::ADDR_W-1:0] pixel_address,
  output logic                        write_enable,
  output logic [3:0]                  pixel_color,
  output logic                        icon_done,
  output logic                        last_of_byte,
  output logic                        empty,
  input  logic                        pop
);

  localparam logic [10:0] SW = 11'(SCREEN_W);
  localparam logic [10:0] SH_CMP = 11'(SCREEN_H);
  localparam logic [rleicon_pkg::ADDR_W-1:0] SH_MUL = rleicon_pkg::ADDR_W'(SCREEN_H);

  rleicon_pkg::rleicon_state_t state, state_next;
  rleicon_pkg::rleicon_pix_t   s1, pix;

  logic [7:0] column_pos, row_pos;
  logic [7:0] eff_col, eff_row;
  logic [5:0] remaining;
  logic [6:0] bits;
  logic       is_run;
  logic       s1_valid;
  logic       out_valid;
  logic       ready1, ready2;
  logic       emit;
  logic       drop;
  logic       done, last;
  logic       col_end, row_end;
  logic       on_screen;
  logic [rleicon_pkg::ADDR_W-1:0] addr_calc;

  // pipeline handshake
  assign ready2 = !out_valid || pop;
  assign ready1 = !s1_valid || ready2;
  assign empty  = !out_valid;

  // empty icon or zero-length run yields nothing
  assign drop = (cfg.icon_width == 8'd0) || (cfg.icon_height == 8'd0) || (item.count == 6'd0);

  // position restarts if a register write left it outside the icon
  always_comb begin
    if ((column_pos >= cfg.icon_width) || (row_pos >= cfg.icon_height)) begin
      eff_col = 8'd0;
      eff_row = 8'd0;
    end else begin
      eff_col = column_pos;
      eff_row = row_pos;
    end
  end

  assign col_end = (eff_col == cfg.icon_width - 8'd1);
  assign row_end = (eff_row == cfg.icon_height - 8'd1);
  assign done    = col_end && row_end;
  assign last    = done || (remaining == 6'd1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rleicon_pkg::ST_IDLE: begin
        if (item_valid && !drop) begin
          state_next = rleicon_pkg::ST_RUN;
        end
      end
      rleicon_pkg::ST_RUN: begin
        if (ready1 && last) begin
          state_next = rleicon_pkg::ST_IDLE;
        end
      end
      default: state_next = rleicon_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_pop = 1'b0;
    emit     = 1'b0;
    unique case (state)
      rleicon_pkg::ST_IDLE: item_pop = item_valid;
      rleicon_pkg::ST_RUN:  emit     = ready1;
      default: begin
        item_pop = 1'b0;
        emit     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rleicon_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // byte load and per-pixel stepping
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= 8'd0;
      row_pos    <= 8'd0;
      remaining  <= 6'd0;
    end else if (item_pop && !drop) begin
      remaining <= item.count;
    end else if (emit) begin
      remaining <= remaining - 6'd1;
      if (done) begin
        column_pos <= 8'd0;
        row_pos    <= 8'd0;
      end else if (row_end) begin
        row_pos    <= 8'd0;
        column_pos <= col_end ? 8'd0 : eff_col + 8'd1;
      end else begin
        row_pos    <= eff_row + 8'd1;
        column_pos <= eff_col;
      end
    end
  end

  // pixel pattern
  always_ff @(posedge clk) begin
    if (item_pop && !drop) begin
      bits   <= item.bits;
      is_run <= item.is_run;
    end else if (emit && !is_run) begin
      bits <= {1'b0, bits[6:1]};
    end
  end

  // screen coordinates of the current pixel
  always_comb begin
    pix.sx    = {cfg.origin_x[10], cfg.origin_x} + {4'b0, eff_col};
    pix.sy    = {cfg.origin_y[10], cfg.origin_y} + {4'b0, eff_row};
    pix.inked = bits[0];
    pix.done  = done;
    pix.last  = last;
    pix.color = cfg.ink_color;
  end

  // stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && emit) begin
      s1 <= pix;
    end
  end

  // clipping and address
  assign on_screen = !s1.sx[11] && (s1.sx[10:0] < SW) && !s1.sy[11] && (s1.sy[10:0] < SH_CMP);
  assign addr_calc = rleicon_pkg::ADDR_W'(s1.sx[10:0]) * SH_MUL
                   + rleicon_pkg::ADDR_W'(s1.sy[10:0]);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      pixel_address <= on_screen ? addr_calc : '0;
      write_enable  <= on_screen && s1.inked;
      pixel_color   <= s1.color;
      icon_done     <= s1.done;
      last_of_byte  <= s1.last;
    end
  end

  `RLEICON_ASSERT_IMPL(a_pos_in_icon, clk, rst, emit, (eff_col < cfg.icon_width) && (eff_row < cfg.icon_height))
  `RLEICON_ASSERT_NEXT(a_last_idles, clk, rst, emit && last, state == rleicon_pkg::ST_IDLE)
  `RLEICON_ASSERT_NEXT(a_done_wraps, clk, rst, emit && done, (column_pos == 8'd0) && (row_pos == 8'd0))
  `RLEICON_ASSERT_NEXT(a_drop_stays, clk, rst, item_pop && drop, state == rleicon_pkg::ST_IDLE)

endmodule

/* rtl/rle_icon_pixel_decoder_unit.sv */
// Run-length icon pixel decoder.
// Input channel (push/full): one compressed icon byte per word. A byte with
// bit 7 set is a run of bits 5..0 pixels of value bit 6; any other byte holds
// seven literal pixels, bit 0 first. Pixels go down each column, then across.
// Result channel (empty/pop): one word per placed pixel with frame-buffer
// address, write enable (inked and on screen), ink colour, icon-done and
// last-of-byte flags. Results come out in order.
// Configuration channel (cfg_valid/cfg_ready, always ready): registers 0..4 are
// width, height, origin x, origin y and ink colour; write only while idle.
// The first pixel of a byte passes through the queue, the sequencer's load
// step, the s1 register and the output register. The pixel sequencer loads
// a byte, emits its pixels in turn while the pipeline is not stalled and
// takes the next byte after the last pixel. Bytes that yield nothing are dropped.
// A two-word queue takes new bytes while the sequencer is busy; when the
// receiver holds pop low the pixel pipeline stalls, then the queue fills and
// full is raised. Synchronous reset empties the queue and pipeline, sets the
// position to column 0, row 0 and loads the register reset values (ink 1).
module rle_icon_pixel_decoder_unit #(
  parameter int SCREEN_W = 240,
  parameter int SCREEN_H = 135
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [7:0]                          code_byte,
  input  logic                                push,
  output logic                                full,
  output logic [rleicon_pkg::ADDR_W-1:0]      pixel_address,
  output logic                                write_enable,
  output logic [3:0]                          pixel_color,
  output logic                                icon_done,
  output logic                                last_of_byte,
  output logic                                empty,
  input  logic                                pop,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rleicon_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rleicon_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rleicon_pkg::rleicon_cfg_t  cfg;
  rleicon_pkg::rleicon_item_t item;
  logic item_valid;
  logic item_pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.icon_width  <= 8'd0;
      cfg.icon_height <= 8'd0;
      cfg.origin_x    <= 11'd0;
      cfg.origin_y    <= 11'd0;
      cfg.ink_color   <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rleicon_pkg::rleicon_reg_t'(cfg_index))
        rleicon_pkg::REG_ICON_WIDTH:  cfg.icon_width  <= cfg_data[7:0];
        rleicon_pkg::REG_ICON_HEIGHT: cfg.icon_height <= cfg_data[7:0];
        rleicon_pkg::REG_ORIGIN_X:    cfg.origin_x    <= cfg_data[10:0];
        rleicon_pkg::REG_ORIGIN_Y:    cfg.origin_y    <= cfg_data[10:0];
        rleicon_pkg::REG_INK_COLOR:   cfg.ink_color   <= cfg_data[3:0];
        default: cfg <= cfg;
      endcase
    end
  end

  rleicon_front u_front (
    .clk        (clk),
    .rst        (rst),
    .code_byte  (code_byte),
    .push       (push),
    .full       (full),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  rleicon_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item          (item),
    .item_valid    (item_valid),
    .item_pop      (item_pop),
    .pixel_address (pixel_address),
    .write_enable  (write_enable),
    .pixel_color   (pixel_color),
    .icon_done     (icon_done),
    .last_of_byte  (last_of_byte),
    .empty         (empty),
    .pop           (pop)
  );

endmodule
